### hdl/lcdsrw_pkg.sv
// Shared types, constants and the frame builder for the LCD serial register writer.
// No dependencies; used by lcdsrw_seq and lcd_serial_register_writer_unit.
package lcdsrw_pkg;

  // Width of the address and value fields sent in each frame
  localparam int FIELD_BITS = 16;
  // Device id (6) + RS + RW + field
  localparam int FRAME_LEN  = FIELD_BITS + 8;
  localparam int BIT_W      = $clog2(FRAME_LEN);
  localparam int INPUT_W    = 16;
  localparam int HALF_W     = 8;
  localparam int HOLD_W     = 12;
  localparam int DEV_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(FRAME_LEN - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [HALF_W-1:0] HALF_RESET   = 8'd2;
  localparam logic [HOLD_W-1:0] GAP_RESET    = 12'd20;
  localparam logic [DEV_W-1:0]  DEVICE_RESET = 6'h1C;

  // Input operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Bit positions in the pin level vector
  localparam int PIN_SEL = 2;
  localparam int PIN_CLK = 1;
  localparam int PIN_DAT = 0;

  typedef struct packed {
    logic [HALF_W-1:0] half_period_ticks;
    logic [HOLD_W-1:0] gap_ticks;
    logic [DEV_W-1:0]  device_id;
  } cfg_t;

  typedef struct packed {
    logic [2:0] levels;
    logic       busy;
    logic       finished;
    logic       rejected;
  } seq_res_t;

  // Frame layout, MSB first: device id, RS, RW (always 0), field
  function automatic logic [FRAME_LEN-1:0] build_frame(
    input logic             rs,
    input logic [DEV_W-1:0] dev,
    input logic [INPUT_W-1:0] field
  );
    logic [FRAME_LEN-1:0] f;
    f = '0;
    f[FIELD_BITS-1:0] = FIELD_BITS'(field);
    f[FIELD_BITS] = 1'b0;
    f[FIELD_BITS+1] = rs;
    f[FRAME_LEN-1:FIELD_BITS+2] = dev;
    return f;
  endfunction

endpackage

### hdl/lcdsrw_seq.sv
// Write sequencer: phase, bit and hold counters, frame shift and pin levels.
// Depends on lcdsrw_pkg.
module lcdsrw_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           op,
  input  logic [lcdsrw_pkg::INPUT_W-1:0] reg_address,
  input  logic [lcdsrw_pkg::INPUT_W-1:0] reg_value,
  input  lcdsrw_pkg::cfg_t               cfg,
  output lcdsrw_pkg::seq_res_t           res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_PRE, PH_SEL1, PH_LOW1, PH_HIGH1, PH_GAPD,
    PH_GAPS, PH_SEL2, PH_LOW2, PH_HIGH2, PH_END
  } phase_t;

  phase_t                              phase_r, phase_nxt, enter_ph;
  logic [lcdsrw_pkg::BIT_W-1:0]        bit_r, bit_nxt;
  logic [lcdsrw_pkg::HOLD_W-1:0]       hold_r, hold_nxt, hold_dec, short_hold, long_hold;
  logic [lcdsrw_pkg::FRAME_LEN-1:0]    frame_r, frame_nxt;
  logic [lcdsrw_pkg::INPUT_W-1:0]      held_r, held_nxt;
  logic [2:0]                          pins_r, pins_nxt;
  logic                                enter_en;

  assign short_hold = (cfg.half_period_ticks == '0) ? lcdsrw_pkg::HOLD_W'(1)
                    : lcdsrw_pkg::HOLD_W'(cfg.half_period_ticks);
  assign long_hold  = (cfg.gap_ticks == '0) ? lcdsrw_pkg::HOLD_W'(1) : cfg.gap_ticks;
  assign hold_dec   = (hold_r != '0) ? hold_r - lcdsrw_pkg::HOLD_W'(1) : hold_r;

  always_comb begin
    phase_nxt    = phase_r;
    bit_nxt      = bit_r;
    hold_nxt     = hold_r;
    frame_nxt    = frame_r;
    held_nxt     = held_r;
    pins_nxt     = pins_r;
    enter_en     = 1'b0;
    enter_ph     = PH_IDLE;
    res.finished = 1'b0;
    res.rejected = 1'b0;

    if (op == lcdsrw_pkg::OP_START) begin
      if (phase_r != PH_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        held_nxt  = reg_value;
        frame_nxt = lcdsrw_pkg::build_frame(1'b0, cfg.device_id, reg_address);
        bit_nxt   = lcdsrw_pkg::LAST_BIT;
        enter_en  = 1'b1;
        enter_ph  = PH_PRE;
      end
    end else if (phase_r != PH_IDLE) begin
      hold_nxt = hold_dec;
      if (hold_dec == '0) begin
        enter_en = 1'b1;
        unique case (phase_r)
          PH_PRE:   enter_ph = PH_SEL1;
          PH_SEL1:  enter_ph = PH_LOW1;
          PH_LOW1:  enter_ph = PH_HIGH1;
          PH_HIGH1: begin
            if (bit_r == '0) begin
              enter_ph = PH_GAPD;
            end else begin
              bit_nxt  = bit_r - lcdsrw_pkg::BIT_W'(1);
              enter_ph = PH_LOW1;
            end
          end
          PH_GAPD:  enter_ph = PH_GAPS;
          PH_GAPS:  enter_ph = PH_SEL2;
          PH_SEL2:  enter_ph = PH_LOW2;
          PH_LOW2:  enter_ph = PH_HIGH2;
          PH_HIGH2: begin
            if (bit_r == '0) begin
              enter_ph = PH_END;
            end else begin
              bit_nxt  = bit_r - lcdsrw_pkg::BIT_W'(1);
              enter_ph = PH_LOW2;
            end
          end
          default: begin
            // end segment done: drop back to idle
            enter_en     = 1'b0;
            phase_nxt    = PH_IDLE;
            hold_nxt     = '0;
            res.finished = 1'b1;
          end
        endcase
      end
    end

    // Segment entry: load the hold and set the levels of the new segment
    if (enter_en) begin
      phase_nxt = enter_ph;
      hold_nxt  = short_hold;
      unique case (enter_ph) inside
        PH_PRE:  pins_nxt = 3'b111;
        PH_SEL1: pins_nxt[lcdsrw_pkg::PIN_SEL] = 1'b0;
        PH_SEL2: begin
          pins_nxt[lcdsrw_pkg::PIN_SEL] = 1'b0;
          frame_nxt = lcdsrw_pkg::build_frame(1'b1, cfg.device_id, held_r);
          bit_nxt   = lcdsrw_pkg::LAST_BIT;
        end
        PH_LOW1, PH_LOW2: begin
          pins_nxt[lcdsrw_pkg::PIN_CLK] = 1'b0;
          pins_nxt[lcdsrw_pkg::PIN_DAT] = frame_nxt[bit_nxt];
        end
        PH_HIGH1, PH_HIGH2: pins_nxt[lcdsrw_pkg::PIN_CLK] = 1'b1;
        PH_GAPD: begin
          pins_nxt[lcdsrw_pkg::PIN_DAT] = 1'b1;
          hold_nxt = long_hold;
        end
        PH_GAPS: begin
          pins_nxt[lcdsrw_pkg::PIN_SEL] = 1'b1;
          hold_nxt = long_hold;
        end
        PH_END:  pins_nxt[lcdsrw_pkg::PIN_SEL] = 1'b1;
        default: ;
      endcase
    end

    res.levels = (op == lcdsrw_pkg::OP_START) ? pins_nxt : pins_r;
    res.busy   = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      hold_r  <= '0;
      frame_r <= '0;
      held_r  <= '0;
      pins_r  <= 3'b111;
    end else if (step) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      hold_r  <= hold_nxt;
      frame_r <= frame_nxt;
      held_r  <= held_nxt;
      pins_r  <= pins_nxt;
    end
  end

endmodule

### hdl/lcd_serial_register_writer_unit.sv
// An accepted input beat gives its result beat in the next cycle, from the result register.
// Throughput: one beat per cycle while out_stall is low; the sequencer updates in the accept
// cycle and the result register frees the input side whenever its beat is taken.
// Reset (rst_n low, synchronous): sequencer idle with all pins high, no result
// held, half period 2, gap 20, device id 0x1C. Depends on lcdsrw_pkg, lcdsrw_seq.
module lcd_serial_register_writer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [lcdsrw_pkg::INPUT_W-1:0]    in_reg_address,
  input  logic [lcdsrw_pkg::INPUT_W-1:0]    in_reg_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_select_level,
  output logic                              out_clock_level,
  output logic                              out_data_level,
  output logic                              out_busy_res,
  output logic                              out_finished,
  output logic                              out_rejected,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcdsrw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdsrw_pkg::CFG_DATA_W-1:0] cfg_data
);

  lcdsrw_pkg::cfg_t     cfg_r;
  lcdsrw_pkg::seq_res_t seq_res;
  lcdsrw_pkg::seq_res_t res_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_accept;

  // Configuration: always ready, writes beyond the register list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= lcdsrw_pkg::HALF_RESET;
      cfg_r.gap_ticks         <= lcdsrw_pkg::GAP_RESET;
      cfg_r.device_id         <= lcdsrw_pkg::DEVICE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcdsrw_pkg::CFG_HALF_PERIOD:
          cfg_r.half_period_ticks <= cfg_data[lcdsrw_pkg::HALF_W-1:0];
        lcdsrw_pkg::CFG_GAP:
          cfg_r.gap_ticks <= cfg_data[lcdsrw_pkg::HOLD_W-1:0];
        lcdsrw_pkg::CFG_DEVICE_ID:
          cfg_r.device_id <= cfg_data[lcdsrw_pkg::DEV_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall the input only while a finished beat is still waiting downstream
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Sequencer advances on every accepted beat; its result is combinational
  lcdsrw_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_accept),
    .op          (in_op),
    .reg_address (in_reg_address),
    .reg_value   (in_reg_value),
    .cfg         (cfg_r),
    .res         (seq_res)
  );

  // Result register: load on accept, hold while stalled, drop once taken
  assign out_valid_nxt = in_accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= seq_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_select_level = res_r.levels[lcdsrw_pkg::PIN_SEL];
  assign out_clock_level  = res_r.levels[lcdsrw_pkg::PIN_CLK];
  assign out_data_level   = res_r.levels[lcdsrw_pkg::PIN_DAT];
  assign out_busy_res     = res_r.busy;
  assign out_finished     = res_r.finished;
  assign out_rejected     = res_r.rejected;

  // An accepted beat always shows up as a result in the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted beat produced no result");

  // Completion and rejection never land on the same beat
  a_fin_rej_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_finished && out_rejected))
    else $error("finished and rejected on one beat");

  // A rejected start only happens while a sequence is running
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |-> out_busy_res)
    else $error("rejected start reported while idle");

  // Outside a sequence select and clock sit high
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy_res) |-> (out_select_level && out_clock_level))
    else $error("select or clock low while idle");

endmodule
